// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top, flow_vector_color_coding
// needs aclk and aresetn in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FVC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define FVC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/fvc_pkg.sv =====
// types and constants of the flow vector color coding pipeline
// no dependencies
package fvc_pkg;

    localparam int SQRT_STEPS = 24;
    localparam int CORDIC_MAX = 24;
    localparam int DIV_STEPS  = 15;
    localparam int CW         = 36;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    localparam logic [31:0] ANGLE_HALF_PI  = 32'h4000_0000;
    localparam logic [31:0] ANGLE_PI       = 32'h8000_0000;
    localparam logic [31:0] ANGLE_3HALF_PI = 32'hC000_0000;

    localparam logic [7:0] REG_MAG_LOW  = 8'd0;
    localparam logic [7:0] REG_MAG_HIGH = 8'd1;
    localparam logic [7:0] REG_GAIN     = 8'd2;
    localparam logic [7:0] REG_ORDER    = 8'd3;

    localparam logic [2:0] SEC_RED_BLUE   = 3'd0;
    localparam logic [2:0] SEC_BLUE_A     = 3'd1;
    localparam logic [2:0] SEC_BLUE_B     = 3'd2;
    localparam logic [2:0] SEC_GREEN      = 3'd3;
    localparam logic [2:0] SEC_YELLOW_A   = 3'd4;
    localparam logic [2:0] SEC_YELLOW_B   = 3'd5;
    localparam logic [2:0] SEC_RED_A      = 3'd6;
    localparam logic [2:0] SEC_RED_B      = 3'd7;

    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic        valid;
        logic [47:0] v;
        logic [47:0] r;
    } sqrt_cell_t;

    typedef struct packed {
        logic                 valid;
        logic                 hold;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [31:0]          z;
    } cordic_cell_t;

    typedef struct packed {
        logic        valid;
        logic [23:0] rem;
        logic [14:0] q;
    } div_cell_t;

    typedef struct packed {
        logic        over;
        logic        le;
        logic        full;
        logic [15:0] wr;
        logic [15:0] wg;
        logic [15:0] wb;
    } side_t;

endpackage

// ===== rtl/fvc_sqrt_cell.sv =====
// one bit step of the pipelined square root
// depends on fvc_pkg
module fvc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  fvc_pkg::sqrt_cell_t cell_in,
    output fvc_pkg::sqrt_cell_t cell_out
);
    localparam logic [47:0] BIT_VAL = 48'd1 << (46 - 2 * STEP);

    fvc_pkg::sqrt_cell_t cell_reg, cell_next;
    logic [48:0] trial;

    always_comb begin
        trial = {1'b0, cell_in.r} + {1'b0, BIT_VAL};
        cell_next = cell_in;
        if ({1'b0, cell_in.v} >= trial) begin
            cell_next.v = cell_in.v - trial[47:0];
            cell_next.r = (cell_in.r >> 1) + BIT_VAL;
        end else begin
            cell_next.r = cell_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (ce) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (ce) begin
            cell_reg.v <= cell_next.v;
            cell_reg.r <= cell_next.r;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ===== rtl/fvc_cordic_cell.sv =====
// one rotation of the vectoring cordic, or a plain register past the stage count
// depends on fvc_pkg
module fvc_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  fvc_pkg::cordic_cell_t cell_in,
    output fvc_pkg::cordic_cell_t cell_out
);
    fvc_pkg::cordic_cell_t cell_reg, cell_next;
    logic signed [fvc_pkg::CW-1:0] dx, dy;

    always_comb begin
        dx = cell_in.cy >>> STAGE;
        dy = cell_in.cx >>> STAGE;
        cell_next = cell_in;
        if (ACTIVE && !cell_in.hold) begin
            if (!cell_in.cy[fvc_pkg::CW-1]) begin
                cell_next.cx = cell_in.cx + dx;
                cell_next.cy = cell_in.cy - dy;
                cell_next.z  = cell_in.z + fvc_pkg::ATAN_TURNS[STAGE];
            end else begin
                cell_next.cx = cell_in.cx - dx;
                cell_next.cy = cell_in.cy + dy;
                cell_next.z  = cell_in.z - fvc_pkg::ATAN_TURNS[STAGE];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (ce) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (ce) begin
            cell_reg.hold <= cell_next.hold;
            cell_reg.cx   <= cell_next.cx;
            cell_reg.cy   <= cell_next.cy;
            cell_reg.z    <= cell_next.z;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ===== rtl/fvc_div_cell.sv =====
// one quotient bit of the restoring divider for the amplitude
// depends on fvc_pkg
module fvc_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic [23:0]       span,
    input  fvc_pkg::div_cell_t cell_in,
    output fvc_pkg::div_cell_t cell_out
);
    fvc_pkg::div_cell_t cell_reg, cell_next;
    logic [24:0] rem2;

    always_comb begin
        rem2 = {cell_in.rem, 1'b0};
        cell_next = cell_in;
        if (rem2 >= {1'b0, span}) begin
            cell_next.rem = 24'(rem2 - {1'b0, span});
            cell_next.q   = {cell_in.q[13:0], 1'b1};
        end else begin
            cell_next.rem = rem2[23:0];
            cell_next.q   = {cell_in.q[13:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (ce) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (ce) begin
            cell_reg.rem <= cell_next.rem;
            cell_reg.q   <= cell_next.q;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ===== rtl/flow_vector_color_coding.sv =====
// Flow vector color coding: one flow vector in, one color out, one beat per clock while the pipe is not held.
// The pipe is 48 stages deep from an accepted input beat to its output beat: a 24-cell
// square root chain beside a 24-cell cordic chain, then a 15-cell divider and the multiply
// stages. All stages advance together; a low m_tready holds the whole pipe
// unless the output register is empty. Configuration is taken on any cycle.
// depends on fvc_pkg, fvc_sqrt_cell, fvc_cordic_cell, fvc_div_cell, assert_macros.svh
`include "assert_macros.svh"

module flow_vector_color_coding #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // flow_x, flow_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // color_first, color_second, color_third
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int NS = fvc_pkg::SQRT_STEPS;
    localparam int ND = fvc_pkg::DIV_STEPS;
    localparam int CW = fvc_pkg::CW;

    logic ce;
    logic [15:0] mag_low_reg, mag_high_reg, gain_reg;
    logic        order_reg;
    logic [31:0] lo_sq_reg;
    logic        inv;
    logic [23:0] span;

    logic               v0_reg, v1_reg;
    logic signed [15:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [31:0]        xx1_reg, yy1_reg;

    fvc_pkg::sqrt_cell_t   sqrt_in_reg;
    fvc_pkg::cordic_cell_t cordic_in_reg, cordic_next;
    fvc_pkg::sqrt_cell_t   sq [NS];
    fvc_pkg::cordic_cell_t cd [NS];
    logic                  over_line_reg [NS];

    logic        v27_reg, le27_reg, over27_reg;
    logic [23:0] diff27_reg;
    logic [15:0] wr27_reg, wg27_reg, wb27_reg;
    logic [15:0] t_ang, beta, alpha, wr_next, wg_next, wb_next;
    logic [23:0] mag;

    fvc_pkg::div_cell_t div_in_reg;
    fvc_pkg::side_t     side_in_reg;
    fvc_pkg::div_cell_t dv [ND];
    fvc_pkg::side_t     side_line_reg [ND];

    logic        v44_reg, v45_reg, v46_reg;
    logic [15:0] amp_reg, amp_next, wr44_reg, wg44_reg, wb44_reg;
    logic [15:0] chr_reg, chg_reg, chb_reg;
    logic [31:0] pr, pg, pb, qr, qg, qb;
    logic [16:0] or_reg, og_reg, ob_reg;
    logic [15:0] sr, sg, sb;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    assign ce        = !m_tvalid_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign inv       = mag_high_reg <= mag_low_reg;
    assign span      = {mag_high_reg - mag_low_reg, 8'h00};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_low_reg  <= 16'd0;
            mag_high_reg <= 16'd256;
            gain_reg     <= 16'd256;
            order_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fvc_pkg::REG_MAG_LOW:  mag_low_reg  <= cfg_data;
                fvc_pkg::REG_MAG_HIGH: mag_high_reg <= cfg_data;
                fvc_pkg::REG_GAIN:     gain_reg     <= cfg_data;
                fvc_pkg::REG_ORDER:    order_reg    <= cfg_data[0];
                default: ;
            endcase
        end
        lo_sq_reg <= mag_low_reg * mag_low_reg;
    end

    // cordic start: quadrant fold and axis cases
    always_comb begin
        cordic_next.valid = v1_reg;
        cordic_next.hold  = 1'b0;
        cordic_next.cx    = CW'(x1_reg) <<< 16;
        cordic_next.cy    = CW'(y1_reg) <<< 16;
        cordic_next.z     = 32'd0;
        if (x1_reg == 16'sd0) begin
            cordic_next.hold = 1'b1;
            cordic_next.z    = y1_reg[15] ? fvc_pkg::ANGLE_3HALF_PI : fvc_pkg::ANGLE_HALF_PI;
        end else if (y1_reg == 16'sd0) begin
            cordic_next.hold = 1'b1;
            cordic_next.z    = x1_reg[15] ? fvc_pkg::ANGLE_PI : 32'd0;
        end else if (x1_reg[15]) begin
            cordic_next.cx = -(CW'(x1_reg) <<< 16);
            cordic_next.cy = -(CW'(y1_reg) <<< 16);
            cordic_next.z  = fvc_pkg::ANGLE_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            sqrt_in_reg.valid   <= 1'b0;
            cordic_in_reg.valid <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            sqrt_in_reg.valid   <= v1_reg;
            cordic_in_reg.valid <= v1_reg;
        end
        if (ce) begin
            x0_reg  <= s_tdata[15:0];
            y0_reg  <= s_tdata[31:16];
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            xx1_reg <= 32'(x0_reg * x0_reg);
            yy1_reg <= 32'(y0_reg * y0_reg);
            sqrt_in_reg.v <= {xx1_reg + yy1_reg, 16'h0000};
            sqrt_in_reg.r <= 48'd0;
            cordic_in_reg.hold <= cordic_next.hold;
            cordic_in_reg.cx   <= cordic_next.cx;
            cordic_in_reg.cy   <= cordic_next.cy;
            cordic_in_reg.z    <= cordic_next.z;
            over_line_reg[0]   <= sqrt_in_reg.v[47:16] > lo_sq_reg;
            for (int k = 1; k < NS; k++) begin
                over_line_reg[k] <= over_line_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_chain
        fvc_sqrt_cell #(.STEP(i)) u_sqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .cell_in (i == 0 ? sqrt_in_reg : sq[(i == 0) ? 0 : i-1]),
            .cell_out(sq[i])
        );
        fvc_cordic_cell #(.STAGE(i), .ACTIVE(i < CORDIC_STAGES)) u_cordic (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .cell_in (i == 0 ? cordic_in_reg : cd[(i == 0) ? 0 : i-1]),
            .cell_out(cd[i])
        );
    end

    // hue weights per sector
    always_comb begin
        mag   = sq[NS-1].r[23:0];
        t_ang = cd[NS-1].z[31:16];
        beta  = t_ang[15] ? {1'b0, t_ang[13:0], 1'b0} : {1'b0, t_ang[12:0], 2'b00};
        alpha = fvc_pkg::ONE_Q15 - beta;
        unique case (t_ang[15:13])
            fvc_pkg::SEC_RED_BLUE: begin
                wr_next = fvc_pkg::ONE_Q15; wg_next = 16'd0; wb_next = beta;
            end
            fvc_pkg::SEC_BLUE_A: begin
                wr_next = alpha + (beta >> 2); wg_next = beta >> 2;
                wb_next = fvc_pkg::ONE_Q15;
            end
            fvc_pkg::SEC_BLUE_B: begin
                wr_next = alpha >> 2; wg_next = beta + (alpha >> 2);
                wb_next = fvc_pkg::ONE_Q15;
            end
            fvc_pkg::SEC_GREEN: begin
                wr_next = 16'd0; wg_next = fvc_pkg::ONE_Q15; wb_next = alpha;
            end
            fvc_pkg::SEC_YELLOW_A, fvc_pkg::SEC_YELLOW_B: begin
                wr_next = beta; wg_next = fvc_pkg::ONE_Q15; wb_next = 16'd0;
            end
            fvc_pkg::SEC_RED_A, fvc_pkg::SEC_RED_B: begin
                wr_next = fvc_pkg::ONE_Q15; wg_next = alpha; wb_next = 16'd0;
            end
            default: begin
                wr_next = 16'd0; wg_next = 16'd0; wb_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v27_reg          <= 1'b0;
            div_in_reg.valid <= 1'b0;
        end else if (ce) begin
            v27_reg          <= sq[NS-1].valid;
            div_in_reg.valid <= v27_reg;
        end
        if (ce) begin
            le27_reg   <= mag <= {mag_low_reg, 8'h00};
            diff27_reg <= mag - {mag_low_reg, 8'h00};
            over27_reg <= over_line_reg[NS-1];
            wr27_reg   <= wr_next;
            wg27_reg   <= wg_next;
            wb27_reg   <= wb_next;
            div_in_reg.rem   <= diff27_reg;
            div_in_reg.q     <= 15'd0;
            side_in_reg.over <= over27_reg;
            side_in_reg.le   <= le27_reg;
            side_in_reg.full <= diff27_reg >= span;
            side_in_reg.wr   <= wr27_reg;
            side_in_reg.wg   <= wg27_reg;
            side_in_reg.wb   <= wb27_reg;
            side_line_reg[0] <= side_in_reg;
            for (int k = 1; k < ND; k++) begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        fvc_div_cell u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .span    (span),
            .cell_in (j == 0 ? div_in_reg : dv[(j == 0) ? 0 : j-1]),
            .cell_out(dv[j])
        );
    end

    // amplitude select
    always_comb begin
        priority if (inv) begin
            amp_next = side_line_reg[ND-1].over ? fvc_pkg::ONE_Q15 : 16'd0;
        end else if (side_line_reg[ND-1].le) begin
            amp_next = 16'd0;
        end else if (side_line_reg[ND-1].full) begin
            amp_next = fvc_pkg::ONE_Q15;
        end else begin
            amp_next = {1'b0, dv[ND-1].q};
        end
    end

    assign pr = amp_reg * wr44_reg;
    assign pg = amp_reg * wg44_reg;
    assign pb = amp_reg * wb44_reg;
    assign qr = chr_reg * gain_reg;
    assign qg = chg_reg * gain_reg;
    assign qb = chb_reg * gain_reg;
    assign sr = or_reg[16] ? 16'hFFFF : or_reg[15:0];
    assign sg = og_reg[16] ? 16'hFFFF : og_reg[15:0];
    assign sb = ob_reg[16] ? 16'hFFFF : ob_reg[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v44_reg      <= 1'b0;
            v45_reg      <= 1'b0;
            v46_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            v44_reg      <= dv[ND-1].valid;
            v45_reg      <= v44_reg;
            v46_reg      <= v45_reg;
            m_tvalid_reg <= v46_reg;
        end
        if (ce) begin
            amp_reg  <= amp_next;
            wr44_reg <= side_line_reg[ND-1].wr;
            wg44_reg <= side_line_reg[ND-1].wg;
            wb44_reg <= side_line_reg[ND-1].wb;
            chr_reg  <= pr[30:15];
            chg_reg  <= pg[30:15];
            chb_reg  <= pb[30:15];
            or_reg   <= qr[31:15];
            og_reg   <= qg[31:15];
            ob_reg   <= qb[31:15];
            m_tdata_reg <= order_reg ? {sr, sg, sb} : {sb, sg, sr};
        end
    end

    `FVC_ASSERT_NOW(a_amp_range, v44_reg, amp_reg <= fvc_pkg::ONE_Q15,
        "amplitude above one")
    `FVC_ASSERT_NOW(a_weight_full, v27_reg,
        wr27_reg == fvc_pkg::ONE_Q15 || wg27_reg == fvc_pkg::ONE_Q15 ||
        wb27_reg == fvc_pkg::ONE_Q15, "no channel at full weight")
    `FVC_ASSERT_NEXT(a_inv_amp, v44_reg && ce && inv && $stable(inv),
        v45_reg && (chr_reg == 16'd0 || chr_reg == wr44_reg || $past(amp_reg) != 16'd0),
        "inverted limits gave partial amplitude")
endmodule

// ===== tb/fvc_checker.sv =====
// checker for the flow vector color coding block: watches the input, output and config beats
// predicts each color from the flow vector and compares field by field; depends on fvc_pkg
`timescale 1ns / 100ps

module fvc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          colors_pending
);
    localparam int STAGES = 16;

    logic [15:0] mag_low, mag_high, gain_q;
    logic        bgr;
    logic [47:0] expected_colors[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] flow_angle(int x, int y);
        longint cx, cy, dx, dy;
        logic [31:0] z;
        if (x == 0) return (y >= 0) ? fvc_pkg::ANGLE_HALF_PI : fvc_pkg::ANGLE_3HALF_PI;
        if (y == 0) return (x > 0) ? 32'd0 : fvc_pkg::ANGLE_PI;
        z = 0;
        cx = longint'(x) * 65536;
        cy = longint'(y) * 65536;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z = fvc_pkg::ANGLE_PI;
        end
        for (int i = 0; i < STAGES && i < fvc_pkg::CORDIC_MAX; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += fvc_pkg::ATAN_TURNS[i];
            end else begin
                cx -= dx; cy += dy; z -= fvc_pkg::ATAN_TURNS[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned scaled(longint unsigned amp, longint unsigned w);
        longint unsigned o;
        o = (((amp * w) >> 15) * gain_q) >> 15;
        return (o > 65535) ? 65535 : o;
    endfunction

    function automatic logic [47:0] color_of(logic [31:0] beat);
        int x, y;
        longint unsigned sum, mag, lo, hi, amp, beta, alpha, wr, wg, wb, r, g, b;
        logic [15:0] t;
        x = int'($signed(beat[15:0]));
        y = int'($signed(beat[31:16]));
        sum = longint'(x) * x + longint'(y) * y;
        mag = isqrt(sum << 16);
        lo = longint'(mag_low) << 8;
        hi = longint'(mag_high) << 8;
        if (hi <= lo) amp = ((sum << 16) > lo * lo) ? 32768 : 0;
        else if (mag <= lo) amp = 0;
        else begin
            amp = ((mag - lo) * 32768) / (hi - lo);
            if (amp > 32768) amp = 32768;
        end
        t = flow_angle(x, y) >> 16;
        beta = (t < 16'd32768) ? longint'(t & 16'd8191) << 2 : longint'(t & 16'd16383) << 1;
        alpha = 32768 - beta;
        case (t[15:13])
            fvc_pkg::SEC_RED_BLUE: begin wr = 32768; wg = 0; wb = beta; end
            fvc_pkg::SEC_BLUE_A: begin
                wr = (4 * alpha + beta) >> 2; wg = beta >> 2; wb = 32768;
            end
            fvc_pkg::SEC_BLUE_B: begin
                wr = alpha >> 2; wg = (alpha + 4 * beta) >> 2; wb = 32768;
            end
            fvc_pkg::SEC_GREEN: begin wr = 0; wg = 32768; wb = alpha; end
            fvc_pkg::SEC_YELLOW_A, fvc_pkg::SEC_YELLOW_B: begin
                wr = beta; wg = 32768; wb = 0;
            end
            default: begin wr = 32768; wg = alpha; wb = 0; end
        endcase
        r = scaled(amp, wr);
        g = scaled(amp, wg);
        b = scaled(amp, wb);
        return bgr ? {r[15:0], g[15:0], b[15:0]} : {b[15:0], g[15:0], r[15:0]};
    endfunction

    assign colors_pending = expected_colors.size();

    always @(posedge aclk) begin
        logic [47:0] want;
        if (!aresetn) begin
            mag_low <= 0;
            mag_high <= 256;
            gain_q <= 256;
            bgr <= 0;
            fail_count <= 0;
            expected_colors.delete();
        end else begin
            if (s_tvalid && s_tready) expected_colors.push_back(color_of(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("color beat with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_colors.pop_front();
                    if (want[15:0] !== m_tdata[15:0])
                        $error("color_first expected %0d actual %0d", want[15:0], m_tdata[15:0]);
                    if (want[31:16] !== m_tdata[31:16])
                        $error("color_second expected %0d actual %0d", want[31:16],
                               m_tdata[31:16]);
                    if (want[47:32] !== m_tdata[47:32])
                        $error("color_third expected %0d actual %0d", want[47:32],
                               m_tdata[47:32]);
                    if (want !== m_tdata) fail_count <= fail_count + 1;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fvc_pkg::REG_MAG_LOW:  mag_low <= cfg_data;
                    fvc_pkg::REG_MAG_HIGH: mag_high <= cfg_data;
                    fvc_pkg::REG_GAIN:     gain_q <= cfg_data;
                    fvc_pkg::REG_ORDER:    bgr <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// top of the flow vector color coding testbench: clock, reset, config and vector stimulus
// depends on fvc_pkg, flow_vector_color_coding and fvc_checker
`timescale 1ns / 100ps

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    int          fail_count, colors_pending;
    int          cycle = 0;
    bit          calm = 0;
    bit          hold_sink = 0;

    always #5 aclk = ~aclk;

    flow_vector_color_coding i_dut (.*);

    fvc_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_sink) m_tready <= 0;
        else m_tready <= calm || ($urandom_range(99) >= 31);
    end

    task automatic send_vector(logic [15:0] x, logic [15:0] y);
        while (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (colors_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_vector();
        logic [15:0] x, y;
        x = $urandom;
        y = $urandom;
        case ($urandom_range(5))
            0: begin x = $signed(x) >>> $urandom_range(12); y = $signed(y) >>> $urandom_range(12); end
            1: x = 0;
            2: y = 0;
            default: ;
        endcase
        send_vector(x, y);
    endtask

    initial begin
        logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff, 16'h0100};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (edges[i]) send_vector(edges[i], 16'h0000);
        foreach (edges[i]) send_vector(16'h0000, edges[i]);
        send_vector(16'h0100, 16'h0100);
        send_vector(16'hff00, 16'h0100);
        send_vector(16'hff00, 16'hff00);
        send_vector(16'h0100, 16'hff00);
        send_vector(16'h0080, 16'h0040);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h7fff);
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(fvc_pkg::REG_MAG_LOW, 16'h0000);
                    write_reg(fvc_pkg::REG_MAG_HIGH, 16'hffff);
                    write_reg(fvc_pkg::REG_GAIN, 16'hffff);
                    write_reg(fvc_pkg::REG_ORDER, 16'h0001);
                end
                1: begin
                    write_reg(fvc_pkg::REG_MAG_LOW, 16'h0200);
                    write_reg(fvc_pkg::REG_MAG_HIGH, 16'h0100);
                    write_reg(fvc_pkg::REG_GAIN, 16'h0000);
                    write_reg(fvc_pkg::REG_ORDER, 16'h0000);
                end
                2: begin
                    write_reg(fvc_pkg::REG_MAG_LOW, 16'hffff);
                    write_reg(fvc_pkg::REG_MAG_HIGH, 16'hffff);
                    write_reg(fvc_pkg::REG_GAIN, 16'h0100);
                    write_reg(8'd9, 16'h1234);
                end
                default: begin
                    write_reg(fvc_pkg::REG_MAG_LOW, $urandom_range(16'h0400));
                    write_reg(fvc_pkg::REG_MAG_HIGH, $urandom_range(16'h4000));
                    write_reg(fvc_pkg::REG_GAIN, $urandom);
                    write_reg(fvc_pkg::REG_ORDER, $urandom);
                end
            endcase
            cfg_valid <= 0;
            calm = (phase == 3);
            if (phase == 4) begin
                hold_sink = 1;
                fork
                    begin repeat (300) @(posedge aclk); hold_sink = 0; end
                    repeat (100) random_vector();
                join
            end
            repeat (180) random_vector();
            drain();
        end
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
